// ===== rtl/platform_interrupt_controller_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the platform interrupt controller
// Shared shorthands for the concurrent checks on the controller ports.
// ----------------------------------------------------------------------------
`ifndef PLATFORM_INTERRUPT_CONTROLLER_TOP_DEFINES_SVH
`define PLATFORM_INTERRUPT_CONTROLLER_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define PIC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PIC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/pic_pkg.sv =====
// ----------------------------------------------------------------------------
// pic_pkg
// Shared codes, address map and default sizes of the interrupt controller.
// ----------------------------------------------------------------------------
package pic_pkg;

  // Request kinds
  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_LINE  = 2'd2,
    MODE_EVAL  = 2'd3
  } mode_t;

  localparam int DEF_NUM_SOURCES   = 256;
  localparam int DEF_PRIORITY_BITS = 3;

  localparam int WORD_BITS = 32;
  localparam int REG_BYTES = 4;

  // Register window bases
  localparam logic [21:0] PEND_BASE  = 22'h001000;
  localparam logic [21:0] EN_BASE    = 22'h002000;
  localparam logic [21:0] THR_BASE   = 22'h200000;
  localparam logic [21:0] CLAIM_BASE = 22'h200004;

endpackage

// ===== rtl/pic_prio_ram.sv =====
// ----------------------------------------------------------------------------
// pic_prio_ram
// Source priority store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pic_prio_ram #(
  parameter int DEPTH = pic_pkg::DEF_NUM_SOURCES,
  parameter int DW    = pic_pkg::DEF_PRIORITY_BITS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/platform_interrupt_controller_top.sv =====
// ----------------------------------------------------------------------------
// platform_interrupt_controller_top
// Single-context interrupt controller with bus, source line and evaluate ops.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its one result
// appears on the out_ ports for a single cycle with out_valid and must be
// captured then. A source line update returns its result in the next cycle
// and leaves busy low, so such requests can follow every cycle. Bus reads
// and writes walk the access one byte per cycle through the priority memory,
// the bit-word registers or the threshold and claim registers, with busy high.
// Evaluate reads the priority memory once per source slot, one slot per cycle,
// and holds busy high. After reset a clearing pass writes the priority memory
// one slot per cycle, with busy high.
// ----------------------------------------------------------------------------
module platform_interrupt_controller_top #(
  parameter int NUM_SOURCES   = pic_pkg::DEF_NUM_SOURCES,
  parameter int PRIORITY_BITS = pic_pkg::DEF_PRIORITY_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [21:0] in_address,
  input  logic [31:0] in_write_data,
  input  logic [2:0]  in_byte_count,
  input  logic [7:0]  in_source_id,
  input  logic        in_line_level,
  output logic        out_valid,
  output logic [31:0] out_read_data,
  output logic        out_irq_request,
  output logic [7:0]  out_winner_id
);

  localparam int NUM_WORDS = (NUM_SOURCES + pic_pkg::WORD_BITS - 1) / pic_pkg::WORD_BITS;
  localparam int SLOTS     = NUM_WORDS * pic_pkg::WORD_BITS;
  localparam int ID_W      = $clog2(SLOTS);
  localparam int WW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int OFFW      = $clog2(4 * SLOTS) + 1;
  localparam logic [21:0] PRIO_END = 22'(4 * NUM_SOURCES);
  localparam logic [21:0] BITS_LEN = 22'(4 * NUM_WORDS);
  localparam logic [21:0] REG_LEN  = 22'(pic_pkg::REG_BYTES);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_BUS, ST_BUS_DONE, ST_SCAN, ST_SCAN_DONE
  } state_t;

  typedef enum logic [2:0] {
    W_NONE, W_PRIO, W_PEND, W_EN, W_THR, W_CLAIM
  } win_t;

  state_t state_r;

  // Architectural state outside the priority memory
  logic [31:0]              pend_r  [NUM_WORDS];
  logic [31:0]              en_r    [NUM_WORDS];
  logic [31:0]              claimd_r[NUM_WORDS];
  logic [PRIORITY_BITS-1:0] thr_r;
  logic [31:0]              claim_r;

  // Request registers
  win_t             win_r;
  logic             is_wr_r;
  logic [OFFW-1:0]  off_r;
  logic [OFFW-1:0]  size_r;
  logic [2:0]       n_r;
  logic [31:0]      wd_r;
  logic [1:0]       bk_r;
  logic [31:0]      rd_r;

  // Read tag for the byte issued last cycle
  logic             tag_v_r;
  logic             tag_prio_r;
  logic [1:0]       tag_k_r;
  logic [7:0]       tag_byte_r;

  // Scan registers
  logic [ID_W:0]            scan_r;
  logic                     ev_v_r;
  logic [ID_W-1:0]          ev_id_r;
  logic [PRIORITY_BITS-1:0] best_r;
  logic [ID_W-1:0]          winner_r;
  logic [ID_W-1:0]          clr_r;

  // Memory ports
  logic                     ram_we;
  logic [ID_W-1:0]          ram_waddr;
  logic [PRIORITY_BITS-1:0] ram_wdata;
  logic [ID_W-1:0]          ram_raddr;
  logic [PRIORITY_BITS-1:0] ram_q;

  // Decode of the incoming request
  win_t            dec_win;
  logic [OFFW-1:0] dec_off;
  logic [OFFW-1:0] dec_size;
  logic [2:0]      dec_n;

  // Current byte of a bus access
  logic [OFFW-1:0] bp;
  logic            bact;
  logic [WW-1:0]   bword;
  logic [1:0]      bbyte;
  logic [7:0]      wbyte;
  logic [ID_W-1:0] bslot;
  logic            prio_hit;

  logic [31:0]     rd_merge;
  logic [31:0]     cid;
  logic [31:0]     winner32;
  logic [WW-1:0]   ev_word;
  logic            ev_hit;

  pic_prio_ram #(
    .DEPTH(SLOTS),
    .DW   (PRIORITY_BITS),
    .AW   (ID_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

  assign busy = (state_r != ST_IDLE);

  // Pick the register window from the first byte of the access
  always_comb begin
    dec_win  = W_NONE;
    dec_off  = '0;
    dec_size = '0;
    if (in_address < PRIO_END) begin
      if (in_address >= 22'd4) begin
        dec_win  = W_PRIO;
        dec_off  = OFFW'(in_address);
        dec_size = OFFW'(PRIO_END);
      end
    end else if (in_address >= pic_pkg::PEND_BASE &&
                 (in_address - pic_pkg::PEND_BASE) < BITS_LEN) begin
      dec_win  = W_PEND;
      dec_off  = OFFW'(in_address - pic_pkg::PEND_BASE);
      dec_size = OFFW'(BITS_LEN);
    end else if (in_address >= pic_pkg::EN_BASE &&
                 (in_address - pic_pkg::EN_BASE) < BITS_LEN) begin
      dec_win  = W_EN;
      dec_off  = OFFW'(in_address - pic_pkg::EN_BASE);
      dec_size = OFFW'(BITS_LEN);
    end else if (in_address >= pic_pkg::THR_BASE &&
                 (in_address - pic_pkg::THR_BASE) < REG_LEN) begin
      dec_win  = W_THR;
      dec_off  = OFFW'(in_address - pic_pkg::THR_BASE);
      dec_size = OFFW'(REG_LEN);
    end else if (in_address >= pic_pkg::CLAIM_BASE &&
                 (in_address - pic_pkg::CLAIM_BASE) < REG_LEN) begin
      dec_win  = W_CLAIM;
      dec_off  = OFFW'(in_address - pic_pkg::CLAIM_BASE);
      dec_size = OFFW'(REG_LEN);
    end
    dec_n = (in_byte_count > 3'd4) ? 3'd4 : in_byte_count;
  end

  // Locate the current byte of the bus access
  always_comb begin
    bp       = off_r + OFFW'(bk_r);
    bact     = (state_r == ST_BUS) && ({1'b0, bk_r} < n_r) && (bp < size_r);
    bword    = WW'(bp >> 2);
    bbyte    = bp[1:0];
    bslot    = ID_W'(bp >> 2);
    wbyte    = wd_r[{bk_r, 3'b000} +: 8];
    prio_hit = bact && (win_r == W_PRIO) && (bp[1:0] == 2'd0);
  end

  // Fold the byte read last cycle into the read word
  always_comb begin
    rd_merge = rd_r;
    if (tag_v_r) begin
      rd_merge[{tag_k_r, 3'b000} +: 8] = tag_prio_r ? 8'(ram_q) : tag_byte_r;
    end
  end

  // Claim id of a claim write: the low byte_count bytes of the data
  always_comb begin
    case (n_r)
      3'd0:    cid = 32'd0;
      3'd1:    cid = {24'd0, wd_r[7:0]};
      3'd2:    cid = {16'd0, wd_r[15:0]};
      3'd3:    cid = {8'd0, wd_r[23:0]};
      default: cid = wd_r;
    endcase
  end

  // Scan stage candidate test
  always_comb begin
    ev_word = WW'(ev_id_r >> 5);
    ev_hit  = ev_v_r && en_r[ev_word][ev_id_r[4:0]] && pend_r[ev_word][ev_id_r[4:0]] &&
              (ram_q >= thr_r);
  end

  assign winner32 = 32'(winner_r);

  // Drive the priority memory
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = bslot;
    ram_wdata = wbyte[PRIORITY_BITS-1:0];
    ram_raddr = bslot;
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
    end else if (state_r == ST_SCAN) begin
      ram_raddr = scan_r[ID_W-1:0];
    end else if (prio_hit && is_wr_r) begin
      ram_we = 1'b1;
    end
  end

  // Sequencer, state updates and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_r     <= '0;
      thr_r     <= '0;
      claim_r   <= '0;
      out_valid <= 1'b0;
      tag_v_r   <= 1'b0;
      ev_v_r    <= 1'b0;
      for (int i = 0; i < NUM_WORDS; i++) begin
        pend_r[i]   <= '0;
        en_r[i]     <= '0;
        claimd_r[i] <= '0;
      end
    end else begin
      out_valid <= 1'b0;
      unique case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == ID_W'(SLOTS - 1)) begin
            state_r <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (start) begin
            win_r   <= dec_win;
            off_r   <= dec_off;
            size_r  <= dec_size;
            n_r     <= dec_n;
            wd_r    <= in_write_data;
            is_wr_r <= (in_mode == pic_pkg::MODE_WRITE);
            bk_r    <= '0;
            rd_r    <= '0;
            tag_v_r <= 1'b0;
            unique case (in_mode)
              pic_pkg::MODE_LINE: begin
                if (32'(in_source_id) < 32'(SLOTS)) begin
                  pend_r[WW'(in_source_id >> 5)][in_source_id[4:0]] <= in_line_level;
                end
                out_valid       <= 1'b1;
                out_read_data   <= '0;
                out_irq_request <= 1'b0;
                out_winner_id   <= '0;
              end
              pic_pkg::MODE_EVAL: begin
                scan_r   <= '0;
                ev_v_r   <= 1'b0;
                best_r   <= '0;
                winner_r <= '0;
                state_r  <= ST_SCAN;
              end
              default: begin
                state_r <= ST_BUS;
              end
            endcase
          end
        end

        ST_BUS: begin
          // Issue one byte, fold in the previous one
          rd_r       <= rd_merge;
          tag_k_r    <= bk_r;
          tag_prio_r <= 1'b0;
          tag_byte_r <= '0;
          tag_v_r    <= bact && !is_wr_r;
          bk_r       <= bk_r + 1'b1;
          if (bact) begin
            case (win_r)
              W_PRIO: begin
                tag_prio_r <= 1'b1;
                tag_v_r    <= prio_hit && !is_wr_r;
              end
              W_PEND: begin
                if (is_wr_r) pend_r[bword][{bbyte, 3'b000} +: 8] <= wbyte;
                tag_byte_r <= pend_r[bword][{bbyte, 3'b000} +: 8];
              end
              W_EN: begin
                if (is_wr_r) en_r[bword][{bbyte, 3'b000} +: 8] <= wbyte;
                tag_byte_r <= en_r[bword][{bbyte, 3'b000} +: 8];
              end
              W_THR: begin
                if (is_wr_r && bp == '0) thr_r <= wbyte[PRIORITY_BITS-1:0];
                if (bp == '0) tag_byte_r <= 8'(thr_r);
              end
              W_CLAIM: begin
                if (is_wr_r) claim_r[{bbyte, 3'b000} +: 8] <= wbyte;
                tag_byte_r <= claim_r[{bbyte, 3'b000} +: 8];
              end
              default: begin
                tag_v_r <= 1'b0;
              end
            endcase
          end
          if (bk_r == 2'd3) begin
            state_r <= ST_BUS_DONE;
          end
        end

        ST_BUS_DONE: begin
          // Apply claim side effects and deliver the result
          tag_v_r <= 1'b0;
          if (win_r == W_CLAIM) begin
            if (is_wr_r) begin
              if (cid < 32'(SLOTS)) begin
                claimd_r[WW'(cid >> 5)][cid[4:0]] <= 1'b0;
              end
            end else if (claim_r < 32'(SLOTS) &&
                         pend_r[WW'(claim_r >> 5)][claim_r[4:0]]) begin
              claimd_r[WW'(claim_r >> 5)][claim_r[4:0]] <= 1'b1;
            end
          end
          out_valid       <= 1'b1;
          out_read_data   <= is_wr_r ? 32'd0 : rd_merge;
          out_irq_request <= 1'b0;
          out_winner_id   <= '0;
          state_r         <= ST_IDLE;
        end

        ST_SCAN: begin
          // Read one slot, judge the slot read last cycle
          ev_v_r  <= (scan_r < (ID_W + 1)'(SLOTS));
          ev_id_r <= scan_r[ID_W-1:0];
          scan_r  <= scan_r + 1'b1;
          if (ev_hit) begin
            if (claimd_r[ev_word][ev_id_r[4:0]]) begin
              pend_r[ev_word][ev_id_r[4:0]] <= 1'b0;
            end else if (ram_q >= best_r) begin
              best_r   <= ram_q;
              winner_r <= ev_id_r;
            end
          end
          if (scan_r == (ID_W + 1)'(SLOTS)) begin
            state_r <= ST_SCAN_DONE;
          end
        end

        ST_SCAN_DONE: begin
          ev_v_r          <= 1'b0;
          claim_r         <= winner32;
          out_valid       <= 1'b1;
          out_read_data   <= '0;
          out_irq_request <= (winner_r != '0);
          out_winner_id   <= winner32[7:0];
          state_r         <= ST_IDLE;
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/pic_checker.sv =====
// ----------------------------------------------------------------------------
// pic_checker
// Port-level checks of the interrupt controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "platform_interrupt_controller_top_defines.svh"

module pic_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [31:0] out_read_data,
  input logic        out_irq_request,
  input logic [7:0]  out_winner_id
);

  // A result is only delivered once the block is idle again
  `PIC_ASSERT(a_valid_when_idle, out_valid |-> !busy, "result strobe while busy")

  // No winner reported when no interrupt is raised
  `PIC_ASSERT(a_no_irq_no_id, (out_valid && !out_irq_request) |-> (out_winner_id == 8'd0), "winner id without irq")

  // Read data and an interrupt never come from the same request
  `PIC_ASSERT(a_rd_not_irq, (out_valid && (out_read_data != 32'd0)) |-> !out_irq_request, "read data on evaluate result")

  // A taken request either answers next cycle or keeps the block busy
  `PIC_ASSERT(a_accept_progress, (start && !busy) |=> (out_valid || busy), "accepted request lost")

  // The clearing pass holds the block busy right after reset
  `PIC_ASSERT_ALWAYS(a_clear_busy, (rst_n && !$past(rst_n)) |-> busy, "not busy after reset")

endmodule

bind platform_interrupt_controller_top pic_checker u_pic_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_read_data  (out_read_data),
  .out_irq_request(out_irq_request),
  .out_winner_id  (out_winner_id)
);
